@@ rtl/core/dldr_pkg.sv @@
package dldr_pkg;

    localparam int DATA_W    = 64;
    localparam int STATUS_W  = 2;
    localparam int DIGIT_W   = 4;
    localparam int IN_DATA_W = 8;
    localparam int PASS_W    = 4;

    localparam logic [PASS_W-1:0]  MAX_PASSES = 4'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
    localparam logic [DIGIT_W-1:0] BCD_FIX    = 4'd6;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_DIV  = 2'd1,
        ST_BAD_DIGIT = 2'd2
    } status_t;

    // program counter of the control store and its step addresses
    typedef logic [1:0] pc_t;
    localparam pc_t STEP_WAIT  = 2'd0;
    localparam pc_t STEP_PASS  = 2'd1;
    localparam pc_t STEP_CHECK = 2'd2;
    localparam pc_t STEP_EMIT  = 2'd3;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_SHIFT,
        OP_SUB,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        C_ACCEPT,
        C_DONE,
        C_LAST,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   jmp_true;
        pc_t   jmp_false;
    } uword_t;

    typedef struct packed {
        logic shift;
        logic sub;
        logic clear;
    } dp_ctrl_t;

    typedef struct packed {
        logic done;
        logic zero_div;
        logic bad_seen;
    } dp_stat_t;

endpackage

@@ rtl/core/dldr_rom.sv @@
module dldr_rom (
    input  dldr_pkg::pc_t    pc,
    output dldr_pkg::uword_t uword
);
    import dldr_pkg::*;

    // wait: take a digit and shift it in
    // pass: subtract until below the divisor or nine passes
    // check: emit on the last digit, else wait again
    // emit: load the output register once it is free, then clear
    always_comb begin
        unique case (pc)
            STEP_WAIT:  uword = '{OP_SHIFT, C_ACCEPT,   STEP_PASS, STEP_WAIT};
            STEP_PASS:  uword = '{OP_SUB,   C_DONE,     STEP_CHECK, STEP_PASS};
            STEP_CHECK: uword = '{OP_NONE,  C_LAST,     STEP_EMIT, STEP_WAIT};
            STEP_EMIT:  uword = '{OP_EMIT,  C_OUT_FREE, STEP_WAIT, STEP_EMIT};
        endcase
    end

endmodule

@@ rtl/core/dldr_datapath.sv @@
module dldr_datapath #(
    parameter int DIGITS = 16,
    localparam int NDIG  = DIGITS + 1,
    localparam int RW    = 4 * NDIG
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dldr_pkg::dp_ctrl_t                ctrl,
    input  logic [dldr_pkg::DIGIT_W-1:0]      digit,
    input  logic [dldr_pkg::DATA_W-1:0]       divisor,
    output dldr_pkg::dp_stat_t                stat,
    output logic [RW-1:0]                     rem
);
    import dldr_pkg::*;

    logic [RW-1:0]     rem_reg, rem_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic              bad_reg, bad_next;
    logic [RW-1:0]     div_bcd;
    logic [RW:0]       diff;
    logic [NDIG-1:0]   borrow;
    logic [RW-1:0]     sub_bcd;
    logic [DIGIT_W-1:0] digit_clamped;
    logic              zero_div;

    // clamp divisor nibbles to nine, top place always zero
    always_comb begin
        div_bcd = '0;
        for (int i = 0; i < DIGITS; i++) begin
            div_bcd[4*i +: 4] = (divisor[4*i +: 4] > DIGIT_MAX) ? DIGIT_MAX
                                                                : divisor[4*i +: 4];
        end
    end

    assign zero_div = ~|div_bcd;

    // binary subtract, then fix each place that borrowed
    assign diff = {1'b0, rem_reg} - {1'b0, div_bcd};

    always_comb begin
        for (int i = 0; i < NDIG - 1; i++) begin
            borrow[i] = rem_reg[4*i+4] ^ div_bcd[4*i+4] ^ diff[4*i+4];
        end
        borrow[NDIG-1] = diff[RW];
        for (int i = 0; i < NDIG; i++) begin
            sub_bcd[4*i +: 4] = diff[4*i +: 4] - (borrow[i] ? BCD_FIX : 4'd0);
        end
    end

    assign digit_clamped = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;

    always_comb begin
        rem_next  = rem_reg;
        pass_next = pass_reg;
        bad_next  = bad_reg;
        priority if (ctrl.clear) begin
            rem_next  = '0;
            pass_next = '0;
            bad_next  = 1'b0;
        end else if (ctrl.shift) begin
            rem_next  = {rem_reg[RW-5:0], digit_clamped};
            pass_next = '0;
            bad_next  = bad_reg | (digit > DIGIT_MAX);
        end else if (ctrl.sub) begin
            rem_next  = sub_bcd;
            pass_next = pass_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg  <= '0;
            pass_reg <= '0;
            bad_reg  <= 1'b0;
        end else begin
            rem_reg  <= rem_next;
            pass_reg <= pass_next;
            bad_reg  <= bad_next;
        end
    end

    assign stat.done     = zero_div | diff[RW] | (pass_reg == MAX_PASSES);
    assign stat.zero_div = zero_div;
    assign stat.bad_seen = bad_reg;
    assign rem           = rem_reg;

endmodule

@@ rtl/core/decimal_long_division_remainder.sv @@
// Remainder of a decimal dividend by a BCD divisor.
// Input requests (s_*) carry one dividend digit each, most significant first;
// s_tlast marks the final digit. Digits above nine are used as nine and flag
// status 2 for that number.
// The divisor is written on the cfg_* channel as packed BCD, lowest digit in
// the low nibble; only the low DIGITS nibbles count. Write it while idle.
// On the last digit one result request leaves on m_*: m_tdata holds the
// remainder in packed BCD, m_tuser the status (0 ok, 1 divisor zero,
// 2 bad digit). A zero divisor gives remainder zero.
// A small microcoded sequencer drives one shared BCD subtractor.
// A digit takes an accept step, the subtract passes (at most nine) plus one
// closing compare, and a check step. The last digit adds an emit step.
// The output register holds a result while m_tready is low; the next number
// proceeds meanwhile and stalls only at its own emit step.
// Reset (aresetn low, synchronous) clears the remainder, flags and output
// valid, and loads divisor 1.
module decimal_long_division_remainder #(
    parameter int DIGITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // dividend digit stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dldr_pkg::IN_DATA_W-1:0]    s_tdata,   // [3:0] digit, [7:4] zero
    input  logic                              s_tlast,
    // remainder stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dldr_pkg::DATA_W-1:0]       m_tdata,   // [63:0] remainder_bcd
    output logic [dldr_pkg::STATUS_W-1:0]     m_tuser,   // [1:0] status
    // divisor register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dldr_pkg::DATA_W-1:0]       cfg_data
);
    import dldr_pkg::*;

    localparam int RW = 4 * (DIGITS + 1);

    pc_t                  pc_reg, pc_next;
    uword_t               uword;
    dp_ctrl_t             ctrl;
    dp_stat_t             stat;
    logic [RW-1:0]        rem;
    logic [DATA_W-1:0]    rem_wide;
    logic [DATA_W-1:0]    divisor_reg;
    logic                 last_reg;
    logic                 out_free;
    logic                 cond_true;
    logic                 accept;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]    m_tdata_reg;
    status_t              m_status_reg;

    // control store
    dldr_rom u_rom (
        .pc    (pc_reg),
        .uword (uword)
    );

    dldr_datapath #(
        .DIGITS (DIGITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .digit   (s_tdata[DIGIT_W-1:0]),
        .divisor (divisor_reg),
        .stat    (stat),
        .rem     (rem)
    );

    // keep the low sixteen places of the remainder
    generate
        if (RW >= DATA_W) begin : g_trunc
            assign rem_wide = rem[DATA_W-1:0];
        end else begin : g_pad
            assign rem_wide = {{(DATA_W-RW){1'b0}}, rem};
        end
    endgenerate

    assign out_free = ~m_tvalid_reg | m_tready;
    assign s_tready = (uword.op == OP_SHIFT);
    assign accept   = s_tvalid & s_tready;

    // branch condition
    always_comb begin
        unique case (uword.cond)
            C_ACCEPT:   cond_true = accept;
            C_DONE:     cond_true = stat.done;
            C_LAST:     cond_true = last_reg;
            C_OUT_FREE: cond_true = out_free;
        endcase
    end

    // next step
    always_comb begin
        pc_next = cond_true ? uword.jmp_true : uword.jmp_false;
    end

    // datapath strobes from the current control word
    always_comb begin
        ctrl.shift = accept;
        ctrl.sub   = (uword.op == OP_SUB) & ~stat.done;
        ctrl.clear = (uword.op == OP_EMIT) & out_free;
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        priority if (ctrl.clear) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= STEP_WAIT;
            m_tvalid_reg <= 1'b0;
            divisor_reg  <= 64'd1;
            last_reg     <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid) begin
                divisor_reg <= cfg_data;
            end
            if (accept) begin
                last_reg <= s_tlast;
            end
        end
    end

    // result payload: zero divisor wins over a bad digit
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            if (stat.zero_div) begin
                m_tdata_reg  <= '0;
                m_status_reg <= ST_ZERO_DIV;
            end else begin
                m_tdata_reg  <= rem_wide;
                m_status_reg <= stat.bad_seen ? ST_BAD_DIGIT : ST_OK;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_status_reg;

`ifndef SYNTHESIS
    a_accept_to_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (pc_reg == STEP_PASS))
        else $error("accepted digit did not start subtract passes");

    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(pc_reg) == STEP_EMIT))
        else $error("result raised outside the emit step");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_ZERO_DIV
                      || m_tuser == ST_BAD_DIGIT))
        else $error("undefined status code on result");

    a_no_sub_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.sub |-> !ctrl.shift && !ctrl.clear)
        else $error("subtract overlaps shift or clear");
`endif

endmodule

@@ tb/sv/decimal_long_division_remainder_tb.sv @@
module decimal_long_division_remainder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dldr_pkg::*;

    localparam int DIGITS        = 16;
    localparam int RDIG          = DIGITS + 1;  // partial remainder keeps one guard digit
    localparam int ITEMS         = 1050;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PCT      = 23;

    // one remainder request as it leaves on m_*
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        status_t           st;
    } rem_result_t;

    // directed plan: a divisor write, a digit checked by the model of the block,
    // or a digit whose remainder is typed in
    typedef enum logic [1:0] {
        ROW_DIVISOR,
        ROW_DIGIT,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [DATA_W-1:0] val;
        logic              lst;
        rem_result_t       want;
    } plan_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [DATA_W-1:0]     cfg_data  = '0;

    // shadow of the block: divisor register, BCD partial remainder, bad digit flag
    logic [DATA_W-1:0]     divisor_shadow;
    logic [3:0]            rem_digits [RDIG];
    logic                  bad_digit_flag;

    rem_result_t           pending_remainders [$];
    int                    items_sent    = 0;
    int                    results_seen  = 0;
    int                    mismatch_count = 0;

    plan_row_t plan [24] = '{
        // divisor 1 straight after reset
        '{ROW_TYPED,   64'd7,  1'b1, '{64'd0, ST_OK}},
        '{ROW_TYPED,   64'd15, 1'b1, '{64'd0, ST_BAD_DIGIT}},
        // zero divisor, also winning over a bad digit
        '{ROW_DIVISOR, 64'd0,  1'b0, '{64'd0, ST_OK}},
        '{ROW_TYPED,   64'd5,  1'b1, '{64'd0, ST_ZERO_DIV}},
        '{ROW_TYPED,   64'd12, 1'b1, '{64'd0, ST_ZERO_DIV}},
        // widest legal divisor
        '{ROW_DIVISOR, 64'h9999_9999_9999_9999, 1'b0, '{64'd0, ST_OK}},
        '{ROW_DIGIT,   64'd9,  1'b0, '{64'd0, ST_OK}},
        '{ROW_TYPED,   64'd9,  1'b1, '{64'h99, ST_OK}},
        '{ROW_TYPED,   64'd0,  1'b1, '{64'd0, ST_OK}},
        // every divisor nibble above nine
        '{ROW_DIVISOR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '{64'd0, ST_OK}},
        '{ROW_DIGIT,   64'd15, 1'b0, '{64'd0, ST_OK}},
        '{ROW_DIGIT,   64'd0,  1'b1, '{64'd0, ST_OK}},
        '{ROW_DIVISOR, 64'h10, 1'b0, '{64'd0, ST_OK}},
        '{ROW_DIGIT,   64'd4,  1'b0, '{64'd0, ST_OK}},
        '{ROW_TYPED,   64'd2,  1'b1, '{64'd2, ST_OK}},
        '{ROW_DIVISOR, 64'd7,  1'b0, '{64'd0, ST_OK}},
        '{ROW_DIGIT,   64'd9,  1'b0, '{64'd0, ST_OK}},
        '{ROW_DIGIT,   64'd9,  1'b0, '{64'd0, ST_OK}},
        '{ROW_DIGIT,   64'd9,  1'b1, '{64'd0, ST_OK}},
        // divisor changed in the middle of a number: nine passes cannot catch up
        '{ROW_DIVISOR, 64'd0,  1'b0, '{64'd0, ST_OK}},
        '{ROW_DIGIT,   64'd9,  1'b0, '{64'd0, ST_OK}},
        '{ROW_DIGIT,   64'd9,  1'b0, '{64'd0, ST_OK}},
        '{ROW_DIVISOR, 64'd5,  1'b0, '{64'd0, ST_OK}},
        '{ROW_DIGIT,   64'd0,  1'b1, '{64'd0, ST_OK}}
    };

    decimal_long_division_remainder #(
        .DIGITS (DIGITS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [3:0] digit, [7:4] zero
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [63:0] remainder_bcd
        .m_tuser   (m_tuser),   // [1:0] status
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Fold one accepted digit into the shadow remainder. Return 1 and the
    // remainder request when the digit closes the number.
    function automatic bit fold_digit(input logic [3:0] dg_in, input bit lst,
                                      output rem_result_t res);
        logic [3:0] dv [RDIG];
        logic [3:0] dg;
        logic [3:0] nib;
        bit         zero_div;
        bit         ge;
        bit         decided;
        int         borrow;
        int         v;
        int         i;
        int         pass;

        res = '0;
        dg = dg_in;
        zero_div = 1'b1;
        // clamp an out-of-range digit and remember it for the status
        if (dg > DIGIT_MAX) begin
            dg = DIGIT_MAX;
            bad_digit_flag = 1'b1;
        end
        for (i = 0; i < RDIG; i++) dv[i] = '0;
        for (i = 0; i < DIGITS; i++) begin
            nib = divisor_shadow[4*i +: 4];
            dv[i] = (nib > DIGIT_MAX) ? DIGIT_MAX : nib;
            if (dv[i] != 0) zero_div = 1'b0;
        end

        // shift one decimal place up; the top digit drops out
        for (i = RDIG - 1; i > 0; i--) rem_digits[i] = rem_digits[i-1];
        rem_digits[0] = dg;

        if (!zero_div) begin
            for (pass = 0; pass < MAX_PASSES; pass++) begin
                ge = 1'b1;
                decided = 1'b0;
                for (i = RDIG - 1; i >= 0; i--) begin
                    if (!decided && rem_digits[i] != dv[i]) begin
                        ge = rem_digits[i] > dv[i];
                        decided = 1'b1;
                    end
                end
                if (!ge) break;
                borrow = 0;
                for (i = 0; i < RDIG; i++) begin
                    v = int'(rem_digits[i]) - int'(dv[i]) - borrow;
                    borrow = (v < 0) ? 1 : 0;
                    if (v < 0) v += 10;
                    rem_digits[i] = v[3:0];
                end
            end
        end

        if (!lst) return 1'b0;

        if (zero_div) begin
            res.st = ST_ZERO_DIV;
        end else begin
            for (i = 0; i < DIGITS; i++) res.rem[4*i +: 4] = rem_digits[i];
            res.st = bad_digit_flag ? ST_BAD_DIGIT : ST_OK;
        end
        for (i = 0; i < RDIG; i++) rem_digits[i] = '0;
        bad_digit_flag = 1'b0;
        return 1'b1;
    endfunction

    // Offer one digit request, with random gaps in front of it, and hold it
    // until accepted. A typed remainder replaces the predicted one.
    task automatic push_digit(input logic [3:0] dg, input bit lst, input bit use_typed,
                              input rem_result_t typed);
        rem_result_t res;
        bit          produced;

        @(negedge aclk);
        while (!(items_sent >= 500 && items_sent < 650) && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-DIGIT_W){1'b0}}, dg};
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        produced = fold_digit(dg, lst, res);
        if (produced) pending_remainders.push_back(use_typed ? typed : res);
    endtask

    // Drop the input, wait for every remainder to leave, then let the last
    // digit finish its passes.
    task automatic await_quiet();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_remainders.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_divisor(input logic [DATA_W-1:0] dv);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= dv;
        do @(posedge aclk); while (!cfg_ready);
        divisor_shadow = dv;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial begin
        logic [DATA_W-1:0] dv;
        logic [3:0]        dg;
        int                nd;
        int                nums;
        int                len;
        int                tail;

        divisor_shadow = 64'd1;
        foreach (rem_digits[i]) rem_digits[i] = '0;
        bad_digit_flag = 1'b0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed plan
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_DIVISOR) begin
                await_quiet();
                write_divisor(plan[i].val);
            end else begin
                push_digit(plan[i].val[3:0], plan[i].lst, plan[i].kind == ROW_TYPED,
                           plan[i].want);
            end
        end

        // random phases: pick a divisor, then a few numbers, now and then
        // leaving one open so the next divisor lands mid-number
        while (items_sent < ITEMS) begin
            dv = '0;
            case ($urandom_range(9))
                0: dv = '0;
                1: dv = 64'h9999_9999_9999_9999;
                2: dv = {$urandom, $urandom};
                3, 4: begin
                    for (int i = 0; i < DIGITS; i++) dv[4*i +: 4] = 4'($urandom_range(9));
                end
                default: begin
                    nd = $urandom_range(1, 4);
                    for (int i = 0; i < nd; i++) dv[4*i +: 4] = 4'($urandom_range(9));
                end
            endcase
            await_quiet();
            write_divisor(dv);

            nums = $urandom_range(1, 6);
            for (int n = 0; n < nums; n++) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
                for (int k = 0; k < len; k++) begin
                    dg = ($urandom_range(19) == 0) ? 4'($urandom_range(10, 15))
                                                   : 4'($urandom_range(9));
                    push_digit(dg, k == len - 1, 1'b0, '0);
                end
            end

            // an open tail under a zero divisor can overflow the guard digit
            if ($urandom_range(5) == 0 || (dv == 0 && $urandom_range(1) == 1)) begin
                tail = $urandom_range(1, (dv == 0) ? 20 : 4);
                for (int k = 0; k < tail; k++) begin
                    dg = ($urandom_range(19) == 0) ? 4'($urandom_range(10, 15))
                                                   : 4'($urandom_range(9));
                    push_digit(dg, 1'b0, 1'b0, '0);
                end
            end
        end

        await_quiet();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // receiver: random back-pressure, one long hold-off while digits keep
    // coming, and a stretch that takes every request at once
    initial begin
        int hold_left;
        bit hold_done;

        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (!hold_done && results_seen >= 40 && s_tvalid) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (results_seen >= 100 && results_seen < 140) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // compare each remainder request with the oldest one predicted
    always @(posedge aclk) begin
        rem_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_remainders.size() == 0) begin
                $error("unexpected remainder request: remainder_bcd %h status %0d",
                       m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = pending_remainders.pop_front();
                if (m_tdata !== want.rem) begin
                    $error("remainder_bcd: expected %h, actual %h", want.rem, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== want.st) begin
                    $error("status: expected %0d, actual %0d", want.st, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
